// ----- sv/rpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types, constants and helper functions for the RGB pixel pulse
// encoder: field widths, register indexes, symbol timing and queue sizing.
// ----------------------------------------------------------------------------
package rpe_pkg;

  // Field widths.
  localparam int SLOT_W    = 4;
  localparam int COLOR_W   = 8;
  localparam int PROD_W    = 2 * COLOR_W;
  localparam int ORDER_W   = 6;
  localparam int SEL_W     = 2;
  localparam int WORD_W    = 3 * COLOR_W;
  localparam int BITNUM_W  = 5;
  localparam int TICK_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Number of LEDs in the chain; pixels addressed at or above it are dropped.
  localparam int LED_SLOTS = 16;

  // Symbols per pixel and the position of the final one.
  localparam int                SYMBOLS  = WORD_W;
  localparam logic [BITNUM_W-1:0] LAST_BIT = BITNUM_W'(SYMBOLS - 1);

  // Pulse timing in ticks.
  localparam logic [TICK_W-1:0] ONE_HIGH  = 4'd8;
  localparam logic [TICK_W-1:0] ONE_LOW   = 4'd4;
  localparam logic [TICK_W-1:0] ZERO_HIGH = 4'd4;
  localparam logic [TICK_W-1:0] ZERO_LOW  = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 2'd1;

  // Register reset values: full brightness, GRB wire order.
  localparam logic [COLOR_W-1:0] BRIGHTNESS_RESET    = 8'd255;
  localparam logic [ORDER_W-1:0] CHANNEL_ORDER_RESET = 6'd18;

  // Queue between the front and back parts.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One scaled pixel waiting to be sent.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } pixel_word_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Exact floor(p / 255) for p up to 255 * 255.
  function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] sum;
    sum = {1'b0, p} + {1'b0, (p >> COLOR_W)} + (PROD_W + 1)'(1);
    return sum[PROD_W-1:COLOR_W];
  endfunction

endpackage

// ----- sv/rpe_front.sv -----
// ----------------------------------------------------------------------------
// rpe_front
// Accepts pixels, scales each color by the brightness register and packs the
// three scaled bytes into the wire word according to the channel order.
// ----------------------------------------------------------------------------
module rpe_front
  import rpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SLOT_W-1:0]    pixel_slot,
  input  logic [COLOR_W-1:0]   red,
  input  logic [COLOR_W-1:0]   green,
  input  logic [COLOR_W-1:0]   blue,
  input  logic [COLOR_W-1:0]   brightness,
  input  logic [ORDER_W-1:0]   channel_order,
  input  fifo_status_t         fifo_status,
  output logic                 push,
  output pixel_word_t          push_data
);

  logic                 s1_valid;
  logic [SLOT_W-1:0]    s1_slot;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    prod_g;
  logic [PROD_W-1:0]    prod_b;
  logic                 in_range;
  logic [COLOR_W-1:0]   scaled_r;
  logic [COLOR_W-1:0]   scaled_g;
  logic [COLOR_W-1:0]   scaled_b;
  logic [SEL_W-1:0]     sel_r;
  logic [SEL_W-1:0]     sel_g;
  logic [SEL_W-1:0]     sel_b;
  logic [COLOR_W-1:0]   wire_byte [3];

  // The multiply stage holds when its result cannot move into the queue.
  assign in_stall = s1_valid && fifo_status.full;
  assign push     = s1_valid && !fifo_status.full;
  assign in_range = 32'(pixel_slot) < LED_SLOTS;

  // Multiply stage: one 8x8 product per color.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_slot <= pixel_slot;
      prod_r  <= PROD_W'(red)   * PROD_W'(brightness);
      prod_g  <= PROD_W'(green) * PROD_W'(brightness);
      prod_b  <= PROD_W'(blue)  * PROD_W'(brightness);
    end
  end

  // Divide by 255 and route each color to its wire slot.
  assign scaled_r = div255(prod_r);
  assign scaled_g = div255(prod_g);
  assign scaled_b = div255(prod_b);
  assign sel_r    = channel_order[5:4];
  assign sel_g    = channel_order[3:2];
  assign sel_b    = channel_order[1:0];

  // Blue wins over green, green over red; an unnamed slot is zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sel_b == SEL_W'(i)) begin
        wire_byte[i] = scaled_b;
      end else if (sel_g == SEL_W'(i)) begin
        wire_byte[i] = scaled_g;
      end else if (sel_r == SEL_W'(i)) begin
        wire_byte[i] = scaled_r;
      end else begin
        wire_byte[i] = '0;
      end
    end
  end

  assign push_data.slot = s1_slot;
  assign push_data.word = {wire_byte[0], wire_byte[1], wire_byte[2]};

endmodule

// ----- sv/rpe_fifo.sv -----
// ----------------------------------------------------------------------------
// rpe_fifo
// Short queue of packed pixel words between the front and back parts, so
// each side can stall on its own.
// ----------------------------------------------------------------------------
module rpe_fifo
  import rpe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pixel_word_t   push_data,
  input  logic          pop,
  output pixel_word_t   head,
  output fifo_status_t  status
);

  pixel_word_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;

  assign status.full  = count == FIFO_CNT_W'(FIFO_DEPTH);
  assign status.empty = count == '0;
  assign head         = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("queue written while full");

  // The back never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("queue read while empty");

endmodule

// ----- sv/rpe_back.sv -----
// ----------------------------------------------------------------------------
// rpe_back
// Serializes each queued pixel word into 24 pulse symbols, most significant
// bit first, through a registered output stage.
// ----------------------------------------------------------------------------
module rpe_back
  import rpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pixel_word_t           head,
  input  fifo_status_t          fifo_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_W-1:0]     slot_out,
  output logic [BITNUM_W-1:0]   bit_number,
  output logic [TICK_W-1:0]     high_ticks,
  output logic [TICK_W-1:0]     low_ticks,
  output logic                  last_symbol
);

  logic                  busy;
  logic [WORD_W-1:0]     word;
  logic [SLOT_W-1:0]     slot;
  logic [BITNUM_W-1:0]   cnt;
  logic                  advance;
  logic                  have_src;
  logic                  emit;
  logic [WORD_W-1:0]     src_word;
  logic [SLOT_W-1:0]     src_slot;
  logic [BITNUM_W-1:0]   src_cnt;
  logic                  src_bit;

  // The output register may load when empty or when its symbol is taken.
  assign advance  = !out_valid || !out_stall;
  assign have_src = busy || !fifo_status.empty;
  assign emit     = advance && have_src;
  assign pop      = emit && !busy;

  // Symbol source: the pixel in flight, or a fresh one from the queue.
  assign src_word = busy ? word : head.word;
  assign src_slot = busy ? slot : head.slot;
  assign src_cnt  = busy ? cnt  : '0;
  assign src_bit  = src_word[WORD_W-1];

  // Serializer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (emit) begin
      busy <= src_cnt != LAST_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word <= src_word << 1;
      slot <= src_slot;
      cnt  <= src_cnt + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= have_src;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot_out    <= src_slot;
      bit_number  <= src_cnt;
      high_ticks  <= src_bit ? ONE_HIGH : ZERO_HIGH;
      low_ticks   <= src_bit ? ONE_LOW  : ZERO_LOW;
      last_symbol <= src_cnt == LAST_BIT;
    end
  end

  // While a pixel is in flight the next symbol index is between 1 and 23.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0 && cnt <= LAST_BIT))
    else $error("serializer count out of range");

  // Sending the final symbol of a pixel ends that pixel.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && src_cnt == LAST_BIT) |=> !busy)
    else $error("serializer still busy after last symbol");

endmodule

// ----- sv/rgb_pixel_pulse_encoder_top.sv -----
// ----------------------------------------------------------------------------
// rgb_pixel_pulse_encoder_top
// Pulse symbol encoder for a chain of RGB LEDs: brightness scaling, wire
// channel ordering and expansion of each pixel into 24 timed pulse symbols.
// ----------------------------------------------------------------------------
// Each accepted pixel yields 24 output symbols, one per cycle while the
// output is not stalled; the bit serializer in the back part, which sends
// one symbol per cycle, sets that pace. The front part (a multiply stage,
// then divide-by-255 and channel routing) feeds a two-entry queue and keeps
// accepting pixels while the serializer works, until the queue is full.
// When the queue is empty, the first symbol of a pixel passes through the
// multiply stage register, the queue and the output register before it is
// presented. Pixels addressed at or beyond the chain length are accepted
// and produce no symbols. Register writes on the configuration port are
// always ready and should be made while idle.
module rgb_pixel_pulse_encoder_top
  import rpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Pixel input.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SLOT_W-1:0]      pixel_slot,
  input  logic [COLOR_W-1:0]     red,
  input  logic [COLOR_W-1:0]     green,
  input  logic [COLOR_W-1:0]     blue,
  // Symbol output.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLOT_W-1:0]      slot_out,
  output logic [BITNUM_W-1:0]    bit_number,
  output logic [TICK_W-1:0]      high_ticks,
  output logic [TICK_W-1:0]      low_ticks,
  output logic                   last_symbol,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data
);

  logic [COLOR_W-1:0]  brightness;
  logic [ORDER_W-1:0]  channel_order;
  logic                push;
  logic                pop;
  pixel_word_t         push_data;
  pixel_word_t         head;
  fifo_status_t        fifo_status;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHTNESS_RESET;
      channel_order <= CHANNEL_ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BRIGHTNESS:    brightness    <= cfg_data[COLOR_W-1:0];
        CFG_CHANNEL_ORDER: channel_order <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  rpe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_slot    (pixel_slot),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .brightness    (brightness),
    .channel_order (channel_order),
    .fifo_status   (fifo_status),
    .push          (push),
    .push_data     (push_data)
  );

  rpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (fifo_status)
  );

  rpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fifo_status (fifo_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_out    (slot_out),
    .bit_number  (bit_number),
    .high_ticks  (high_ticks),
    .low_ticks   (low_ticks),
    .last_symbol (last_symbol)
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the RGB pixel pulse encoder. Pixels are driven
// through the stall handshake and registers through the configuration port.
// An internal predictor expands each accepted pixel into its 24 expected
// pulse symbols, and every symbol transfer is checked against the oldest
// expectation, one field at a time.
// ----------------------------------------------------------------------------
module tb;
  import rpe_pkg::*;

  // Register indexes that map to no register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 2'd3;

  // A slot select that points past the three wire slots.
  localparam logic [SEL_W-1:0] DROPPED_SLOT = 2'd3;

  // Channel order settings used by the directed tests.
  localparam logic [CFG_DAT_W-1:0] ORDER_GRB        = 8'd18;
  localparam logic [CFG_DAT_W-1:0] ORDER_RGB        = 8'd6;
  localparam logic [CFG_DAT_W-1:0] ORDER_RGB_HIBITS = 8'hC6;
  localparam logic [CFG_DAT_W-1:0] ORDER_ALL_DROP   = 8'd63;
  localparam logic [CFG_DAT_W-1:0] ORDER_RED_DROP   = 8'd54;
  localparam logic [CFG_DAT_W-1:0] ORDER_ALL_SLOT0  = 8'd0;
  localparam logic [CFG_DAT_W-1:0] ORDER_RG_SHARED  = 8'd22;
  localparam logic [CFG_DAT_W-1:0] ORDER_BGR        = 8'd36;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int SET_ITEMS      = 30;
  localparam int SETS_PER_PHASE = 3;

  // One expected pulse symbol.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [BITNUM_W-1:0] bit_pos;
    logic [TICK_W-1:0]   high;
    logic [TICK_W-1:0]   low;
    logic                last;
  } symbol_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [SLOT_W-1:0]    pixel_slot  = '0;
  logic [COLOR_W-1:0]   red         = '0;
  logic [COLOR_W-1:0]   green       = '0;
  logic [COLOR_W-1:0]   blue        = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [SLOT_W-1:0]    slot_out;
  logic [BITNUM_W-1:0]  bit_number;
  logic [TICK_W-1:0]    high_ticks;
  logic [TICK_W-1:0]    low_ticks;
  logic                 last_symbol;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;

  // Predictor copy of the registers.
  logic [COLOR_W-1:0]   model_brightness = BRIGHTNESS_RESET;
  logic [ORDER_W-1:0]   model_order      = CHANNEL_ORDER_RESET;

  symbol_t expected_symbols[$];
  int      error_count        = 0;
  int      quiet_cycles       = 0;
  int      sender_idle_pct    = 0;
  int      receiver_stall_pct = 0;

  rgb_pixel_pulse_encoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_slot  (pixel_slot),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_out    (slot_out),
    .bit_number  (bit_number),
    .high_ticks  (high_ticks),
    .low_ticks   (low_ticks),
    .last_symbol (last_symbol),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  // Brightness scaling with truncation: value * brightness / 255.
  function automatic logic [COLOR_W-1:0] scale_intensity(input logic [COLOR_W-1:0] v);
    int unsigned prod;
    prod = int'(v) * int'(model_brightness);
    return COLOR_W'(prod / 255);
  endfunction

  // Route the scaled colours onto the wire and queue the 24 symbols.
  function automatic void predict_symbols(input logic [SLOT_W-1:0] slot,
                                          input logic [COLOR_W-1:0] r,
                                          input logic [COLOR_W-1:0] g,
                                          input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] lane [3];
    logic [SEL_W-1:0]   sel;
    logic [WORD_W-1:0]  word;
    logic               one;
    symbol_t            sym;
    int                 k;
    lane[0] = '0;
    lane[1] = '0;
    lane[2] = '0;
    // Later colours overwrite earlier ones; a select of slot 3 is dropped.
    sel = model_order[5:4];
    if (sel != DROPPED_SLOT) lane[sel] = scale_intensity(r);
    sel = model_order[3:2];
    if (sel != DROPPED_SLOT) lane[sel] = scale_intensity(g);
    sel = model_order[1:0];
    if (sel != DROPPED_SLOT) lane[sel] = scale_intensity(b);
    word = {lane[0], lane[1], lane[2]};
    for (k = 0; k < SYMBOLS; k++) begin
      one         = word[WORD_W-1-k];
      sym.slot    = slot;
      sym.bit_pos = BITNUM_W'(k);
      sym.high    = one ? ONE_HIGH : ZERO_HIGH;
      sym.low     = one ? ONE_LOW : ZERO_LOW;
      sym.last    = (sym.bit_pos == LAST_BIT);
      expected_symbols.push_back(sym);
    end
  endfunction

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Check one symbol transfer against the oldest expectation.
  task automatic check_symbol();
    symbol_t want;
    if (expected_symbols.size() == 0) begin
      report_mismatch($sformatf("symbol with no pending pixel (slot %0d bit %0d)",
                                slot_out, bit_number));
    end else begin
      want = expected_symbols.pop_front();
      compare_field("slot_out", slot_out, want.slot);
      compare_field("bit_number", bit_number, want.bit_pos);
      compare_field("high_ticks", high_ticks, want.high);
      compare_field("low_ticks", low_ticks, want.low);
      compare_field("last_symbol", last_symbol, want.last);
    end
  endtask

  // Track register writes and pixel transfers, and check symbol transfers.
  always @(posedge clk) begin
    if (rst) begin
      model_brightness <= BRIGHTNESS_RESET;
      model_order      <= CHANNEL_ORDER_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BRIGHTNESS) begin
          model_brightness <= cfg_data;
        end else if (cfg_index == CFG_CHANNEL_ORDER) begin
          model_order <= cfg_data[ORDER_W-1:0];
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        predict_symbols(pixel_slot, red, green, blue);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        check_symbol();
      end
    end
  end

  // Random output back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one pixel, with random idle cycles first; entered and left at a
  // falling edge. The valid is left high for a following pixel.
  task automatic send_pixel(input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_slot <= slot;
    red        <= r;
    green      <= g;
    blue       <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // One register write transfer; the valid is lowered by the next pixel.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected symbol has arrived.
  task automatic drain_symbols();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(negedge clk);
  endtask

  task automatic reconfigure_and_send(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [COLOR_W-1:0] r,
                                      input logic [COLOR_W-1:0] g,
                                      input logic [COLOR_W-1:0] b);
    drain_symbols();
    write_register(idx, data);
    send_pixel(slot, r, g, b);
  endtask

  function automatic logic [COLOR_W-1:0] random_intensity();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(255));
    endcase
  endfunction

  // Pixels with the register values left by reset (full brightness, GRB).
  task automatic test_default_registers();
    send_pixel(4'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(4'd15, 8'd255, 8'd255, 8'd255);
    send_pixel(4'd5, 8'hA5, 8'h5A, 8'h3C);
  endtask

  // Brightness extremes and truncation of the scaled value.
  task automatic test_brightness_scaling();
    reconfigure_and_send(CFG_BRIGHTNESS, 8'd0, 4'd3, 8'd255, 8'd255, 8'd255);
    reconfigure_and_send(CFG_BRIGHTNESS, 8'd1, 4'd9, 8'd255, 8'd254, 8'd128);
    reconfigure_and_send(CFG_BRIGHTNESS, 8'd128, 4'd10, 8'd255, 8'd1, 8'd200);
    reconfigure_and_send(CFG_BRIGHTNESS, 8'd254, 4'd12, 8'd255, 8'd128, 8'd0);
    reconfigure_and_send(CFG_BRIGHTNESS, 8'd255, 4'd6, 8'h81, 8'h7E, 8'hFF);
  endtask

  // Wire order: plain orders, dropped colours, shared and empty slots.
  task automatic test_channel_order();
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_RGB, 4'd1, 8'hF0, 8'h0F, 8'h81);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_BGR, 4'd2, 8'hF0, 8'h0F, 8'h81);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_ALL_DROP, 4'd4, 8'hFF, 8'hFF, 8'hFF);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_RED_DROP, 4'd8, 8'hFF, 8'h55, 8'hAA);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_ALL_SLOT0, 4'd13, 8'hFF, 8'h0F, 8'h3C);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_RG_SHARED, 4'd14, 8'hC3, 8'h99, 8'h66);
    reconfigure_and_send(CFG_CHANNEL_ORDER, ORDER_RGB_HIBITS, 4'd7, 8'h12, 8'h34, 8'h56);
  endtask

  // Writes to indexes with no register must leave both registers alone.
  task automatic test_unused_register_index();
    drain_symbols();
    write_register(CFG_CHANNEL_ORDER, ORDER_GRB);
    write_register(CFG_UNUSED_LOW, 8'h00);
    write_register(CFG_UNUSED_HIGH, 8'h2D);
    send_pixel(4'd11, 8'd200, 8'd100, 8'd50);
    send_pixel(4'd0, 8'd255, 8'd0, 8'd255);
  endtask

  // Random pixels in sets, with new register values between sets.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int n;
    int i;
    logic [COLOR_W-1:0] level;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (n = 0; n < SETS_PER_PHASE; n++) begin
      drain_symbols();
      case ($urandom_range(5))
        0:       level = '0;
        1:       level = '1;
        default: level = COLOR_W'($urandom_range(255));
      endcase
      if ($urandom_range(3) == 0) begin
        write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_HIGH)),
                       CFG_DAT_W'($urandom_range(255)));
      end
      write_register(CFG_BRIGHTNESS, level);
      write_register(CFG_CHANNEL_ORDER, CFG_DAT_W'($urandom_range(255)));
      for (i = 0; i < SET_ITEMS; i++) begin
        send_pixel(SLOT_W'($urandom_range(LED_SLOTS - 1)), random_intensity(),
                   random_intensity(), random_intensity());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_registers();
    test_brightness_scaling();
    test_channel_order();
    test_unused_register_index();
    test_random_traffic(17, 64);
    test_random_traffic(64, 17);
    test_random_traffic(0, 0);
    drain_symbols();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
